### rtl/bus_address_range_decoder_top_defines.svh
// Assertion macros used by the checker file of the address decoder.
`ifndef BUS_ADDRESS_RANGE_DECODER_TOP_DEFINES_SVH
`define BUS_ADDRESS_RANGE_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BARD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BARD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bard_pkg.sv
package bard_pkg;

    localparam int MAX_WINDOWS_DEF = 16;
    localparam int ENTRY_W         = 42;
    localparam int IN_DATA_W       = 72;
    localparam int IN_USER_W       = 3;
    localparam int OUT_DATA_W      = 40;
    localparam int OUT_USER_W      = 4;
    localparam logic [7:0] DEFAULT_READ = 8'hFF;

    typedef enum logic [2:0] {
        FUNC_REGISTER = 3'd0,
        FUNC_LOCK     = 3'd1,
        FUNC_READ     = 3'd2,
        FUNC_WRITE    = 3'd3,
        FUNC_CLEAR    = 3'd4
    } t_func;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_LOCKED     = 4'd1,
        ST_FULL       = 4'd2,
        ST_BAD_RANGE  = 4'd3,
        ST_EMPTY      = 4'd4,
        ST_OVERLAP    = 4'd5,
        ST_NOT_LOCKED = 4'd6,
        ST_NO_DEVICE  = 4'd7,
        ST_NO_HANDLER = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_ADDR,
        S_SCAN_CMP,
        S_OV_LOAD,
        S_OV_HOLD,
        S_OV_ADDR,
        S_OV_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    res_load;
        t_status res_status;
        logic    res_route;
        logic    i_clr;
        logic    i_inc;
        logic    j_from_i;
        logic    j_inc;
        logic    hold_load;
        logic    rd_sel_j;
        logic    ram_we;
        logic    count_inc;
        logic    count_clr;
        logic    lock_set;
        logic    unlock;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  locked;
        logic  count_zero;
        logic  full;
        logic  bad_range;
        logic  i_last;
        logic  j_last;
        logic  hit;
        logic  handler_ok;
        logic  overlap;
        logic  out_free;
    } t_stat;

endpackage

### rtl/bard_ram.sv
module bard_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bard_ctrl.sv
module bard_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  bard_pkg::t_stat i_stat,
    output bard_pkg::t_cmd  o_cmd
);

    import bard_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_EMIT;
                unique case (i_stat.func) inside
                    FUNC_REGISTER: begin
                        if (i_stat.locked) begin
                            o_cmd.res_status = ST_LOCKED;
                        end else if (i_stat.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else if (i_stat.bad_range) begin
                            o_cmd.res_status = ST_BAD_RANGE;
                        end else begin
                            o_cmd.ram_we    = 1'b1;
                            o_cmd.count_inc = 1'b1;
                        end
                    end
                    FUNC_LOCK: begin
                        if (i_stat.count_zero) begin
                            o_cmd.res_status = ST_EMPTY;
                        end else begin
                            o_cmd.res_load = 1'b0;
                            o_cmd.i_clr    = 1'b1;
                            n_state        = S_OV_LOAD;
                        end
                    end
                    FUNC_READ, FUNC_WRITE: begin
                        if (!i_stat.locked) begin
                            o_cmd.res_status = ST_NOT_LOCKED;
                        end else if (i_stat.count_zero) begin
                            o_cmd.res_status = ST_NO_DEVICE;
                        end else begin
                            o_cmd.res_load = 1'b0;
                            o_cmd.i_clr    = 1'b1;
                            n_state        = S_SCAN_ADDR;
                        end
                    end
                    FUNC_CLEAR: begin
                        o_cmd.count_clr = 1'b1;
                        o_cmd.unlock    = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN_ADDR: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                // The first window in table order that holds the address wins.
                if (i_stat.hit) begin
                    o_cmd.res_load = 1'b1;
                    if (i_stat.handler_ok) begin
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_route  = 1'b1;
                    end else begin
                        o_cmd.res_status = ST_NO_HANDLER;
                    end
                    n_state = S_EMIT;
                end else if (i_stat.i_last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NO_DEVICE;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_SCAN_ADDR;
                end
            end
            S_OV_LOAD: begin
                n_state = S_OV_HOLD;
            end
            S_OV_HOLD: begin
                o_cmd.hold_load = 1'b1;
                if (i_stat.i_last) begin
                    o_cmd.lock_set   = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.j_from_i = 1'b1;
                    n_state        = S_OV_ADDR;
                end
            end
            S_OV_ADDR: begin
                o_cmd.rd_sel_j = 1'b1;
                n_state        = S_OV_CMP;
            end
            S_OV_CMP: begin
                if (i_stat.overlap) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OVERLAP;
                    n_state          = S_EMIT;
                end else if (i_stat.j_last) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_OV_LOAD;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = S_OV_ADDR;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/bard_dp.sv
module bard_dp #(
    parameter int MAX_WINDOWS = bard_pkg::MAX_WINDOWS_DEF,
    parameter int AW          = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bard_pkg::t_cmd                  i_cmd,
    output bard_pkg::t_stat                 o_stat,
    input  logic [bard_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [bard_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [bard_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [bard_pkg::OUT_USER_W-1:0] o_m_tuser,
    output logic                            o_ram_we,
    output logic [AW-1:0]                   o_ram_waddr,
    output logic [bard_pkg::ENTRY_W-1:0]    o_ram_wdata,
    output logic [AW-1:0]                   o_ram_raddr,
    input  logic [bard_pkg::ENTRY_W-1:0]    i_ram_rdata
);

    import bard_pkg::*;

    localparam int CW = $clog2(MAX_WINDOWS + 1);

    // Captured command.
    t_func       r_func;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;
    logic [15:0] r_rs;
    logic [15:0] r_re;
    logic [7:0]  r_tag;
    logic        r_hr;
    logic        r_hw;

    logic [CW-1:0] r_count;
    logic          r_locked;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [15:0]   r_hold_start;
    logic [15:0]   r_hold_end;

    t_status     r_res_status;
    logic        r_res_route;
    logic [7:0]  r_res_tag;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic [15:0] rd_start;
    logic [15:0] rd_end;
    logic [7:0]  rd_tag;
    logic        rd_reads;
    logic        rd_writes;
    logic [CW-1:0] i_plus;
    logic [CW-1:0] j_plus;

    logic        n_routed;
    logic [7:0]  n_ttag;
    logic        n_isw;
    logic [15:0] n_oaddr;
    logic [7:0]  n_odata;

    assign rd_start  = i_ram_rdata[41:26];
    assign rd_end    = i_ram_rdata[25:10];
    assign rd_tag    = i_ram_rdata[9:2];
    assign rd_reads  = i_ram_rdata[1];
    assign rd_writes = i_ram_rdata[0];

    assign i_plus = r_i + CW'(1);
    assign j_plus = r_j + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_locked    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.count_clr) begin
                r_count <= '0;
            end else if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.unlock) begin
                r_locked <= 1'b0;
            end else if (i_cmd.lock_set) begin
                r_locked <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr  <= i_s_tdata[15:0];
            r_wdata <= i_s_tdata[23:16];
            r_rs    <= i_s_tdata[39:24];
            r_re    <= i_s_tdata[55:40];
            r_tag   <= i_s_tdata[63:56];
            r_hr    <= i_s_tdata[64];
            r_hw    <= i_s_tdata[65];
            r_func  <= t_func'(i_s_tuser);
        end
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= i_plus;
        end
        if (i_cmd.j_from_i) begin
            r_j <= i_plus;
        end else if (i_cmd.j_inc) begin
            r_j <= j_plus;
        end
        if (i_cmd.hold_load) begin
            r_hold_start <= rd_start;
            r_hold_end   <= rd_end;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_route  <= i_cmd.res_route;
            r_res_tag    <= rd_tag;
        end
        if (i_cmd.emit) begin
            r_out_data <= {1'b0, 5'(r_count), n_odata, n_oaddr, n_isw, n_ttag, n_routed};
            r_out_user <= r_res_status;
        end
    end

    // Result fields: zero unless routed, with the default byte on a read that failed.
    always_comb begin
        n_routed = r_res_route;
        n_ttag   = '0;
        n_isw    = 1'b0;
        n_oaddr  = '0;
        n_odata  = '0;
        if (r_res_route) begin
            n_ttag  = r_res_tag;
            n_oaddr = r_addr;
            if (r_func == FUNC_WRITE) begin
                n_isw   = 1'b1;
                n_odata = r_wdata;
            end
        end else if (r_func == FUNC_READ) begin
            n_odata = DEFAULT_READ;
        end
    end

    always_comb begin
        o_stat.func       = r_func;
        o_stat.locked     = r_locked;
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = (r_count >= CW'(MAX_WINDOWS));
        o_stat.bad_range  = (r_rs > r_re);
        o_stat.i_last     = (i_plus >= r_count);
        o_stat.j_last     = (j_plus >= r_count);
        o_stat.hit        = (r_addr >= rd_start) && (r_addr <= rd_end);
        o_stat.handler_ok = (r_func == FUNC_WRITE) ? rd_writes : rd_reads;
        o_stat.overlap    = (r_hold_start <= rd_end) && (rd_start <= r_hold_end);
        o_stat.out_free   = !r_out_valid || i_m_tready;
    end

    assign o_ram_we    = i_cmd.ram_we;
    assign o_ram_waddr = r_count[AW-1:0];
    assign o_ram_wdata = {r_rs, r_re, r_tag, r_hr, r_hw};
    assign o_ram_raddr = i_cmd.rd_sel_j ? r_j[AW-1:0] : r_i[AW-1:0];

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

### rtl/bus_address_range_decoder_top.sv
// Programmable address window decoder. Each beat on the slave side carries one command
// (register a window, lock, read, write, clear) and produces exactly one result beat on
// the master side. The block works on one command at a time. Register, clear and unknown
// commands, a lock of an empty table and an access on an unlocked bus go from the decode
// state straight to the emit state, where the result is loaded into the output register.
// On a locked bus a read or write probes the window table one entry at a time, in an
// address state and a compare state, through the single read port of the table RAM, up
// to the first matching window or, on a miss, over all windows. A lock compares every
// pair of windows through the same port. Each command waits in the emit state for as
// long as the previous result still waits in the output register.
// A new command is accepted in the cycle after its result is loaded, even if the
// downstream side has not yet taken it.
module bus_address_range_decoder_top #(
    parameter int MAX_WINDOWS = bard_pkg::MAX_WINDOWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: access_addr[15:0], write_data[23:16], range_start[39:24],
    // range_end[55:40], device_tag[63:56], has_read[64], has_write[65], zero fill.
    input  logic [bard_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: func[2:0].
    input  logic [bard_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: routed[0], target_tag[8:1], is_write[9], out_addr[25:10],
    // out_data[33:26], entry_count_out[38:34], zero fill.
    output logic [bard_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: status[3:0].
    output logic [bard_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    import bard_pkg::*;

    localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    t_cmd  cmd;
    t_stat stat;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    bard_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bard_dp #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .AW          (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    bard_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WINDOWS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

### rtl/bard_checker.sv
`include "bus_address_range_decoder_top_defines.svh"

module bard_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bard_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [bard_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    import bard_pkg::*;

    // A stalled result beat keeps its contents.
    `BARD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // Commands are worked one at a time, so ready drops after every accepted beat.
    `BARD_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready stayed high after a beat")

    // A routed access always reports success.
    `BARD_ASSERT_NOW(a_routed_ok, m_axis_tvalid && m_axis_tdata[0], m_axis_tuser == ST_OK, "routed access with an error status")

    // Without routing there is no tag, no write flag and no address.
    `BARD_ASSERT_NOW(a_unrouted_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[25:1] == '0, "unrouted result carries routing fields")

endmodule

bind bus_address_range_decoder_top bard_checker u_bard_checker (.*);
